// ===== src/amx_pkg.sv =====
// Package for the accumulator machine executor: opcodes, show selectors,
// ADD forms and the structs passed between issue and execute stages.
// No dependencies; imported by amx_issue, amx_exec and the top level.
package amx_pkg;

    localparam int ADDR_W = 7;
    localparam int DATA_W = 32;

    // Instruction codes, also the unit code reported after each step
    typedef enum logic [2:0] {
        OP_SET   = 3'd0,
        OP_LDR   = 3'd1,
        OP_ADD   = 3'd2,
        OP_INC   = 3'd3,
        OP_DEC   = 3'd4,
        OP_STR   = 3'd5,
        OP_SHW   = 3'd6,
        OP_PAUSE = 3'd7
    } t_op;

    // SHW selectors
    localparam logic [2:0] SHW_ACC = 3'd0;
    localparam logic [2:0] SHW_MAR = 3'd1;
    localparam logic [2:0] SHW_MDR = 3'd2;
    localparam logic [2:0] SHW_UC  = 3'd3;
    localparam logic [2:0] SHW_MEM = 3'd4;

    // ADD address forms
    localparam logic [1:0] FORM_ONE   = 2'd1;
    localparam logic [1:0] FORM_TWO   = 2'd2;
    localparam logic [1:0] FORM_THREE = 2'd3;

    // Issued instruction, held in the execute stage
    typedef struct packed {
        t_op               op;
        logic [1:0]        form;
        logic [DATA_W-1:0] imm;
        logic [2:0]        target;
        logic [ADDR_W-1:0] mar;     // MAR after this instruction
        logic [ADDR_W-1:0] addr_a;  // address on read port A
        logic [ADDR_W-1:0] addr_b;  // address on read port B
        logic [ADDR_W-1:0] a3;
        logic              a_ok;
        logic              b_ok;
        logic              mar_ok;
        logic              a3_ok;
    } t_item;

    // Memory write request from the execute stage
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr;

    // Machine state reported after each instruction
    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [ADDR_W-1:0] mar;
        logic [DATA_W-1:0] mdr;
        logic [2:0]        uc;
        logic [DATA_W-1:0] pc;
        logic              show_valid;
        logic [DATA_W-1:0] show_value;
    } t_result;

endpackage

// ===== src/amx_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module amx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/amx_issue.sv =====
// Issue stage: tracks MAR across accepted instructions and picks the two
// memory read addresses. Depends on amx_pkg.
module amx_issue
    import amx_pkg::*;
#(
    parameter int MEM_WORDS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_op               i_op,
    input  logic              i_has_addresses,
    input  logic [ADDR_W-1:0] i_first_address,
    input  logic [ADDR_W-1:0] i_second_address,
    input  logic [ADDR_W-1:0] i_third_address,
    input  logic [1:0]        i_add_form,
    input  logic [DATA_W-1:0] i_immediate,
    input  logic [2:0]        i_show_target,
    output t_item             o_item
);

    logic [ADDR_W-1:0] r_mar;
    logic [ADDR_W-1:0] n_mar;
    logic [ADDR_W-1:0] base_mar;

    function automatic logic in_range(input logic [ADDR_W-1:0] a);
        return {{(32-ADDR_W){1'b0}}, a} < 32'(MEM_WORDS);
    endfunction

    // MAR after this instruction; ADD moves it to its last operand
    always_comb begin
        base_mar = i_has_addresses ? i_first_address : r_mar;
        n_mar    = base_mar;
        if (i_op == OP_PAUSE) begin
            n_mar = r_mar;
        end else if (i_op == OP_ADD) begin
            case (i_add_form)
                FORM_ONE:   n_mar = i_first_address;
                FORM_TWO:   n_mar = i_second_address;
                FORM_THREE: n_mar = i_third_address;
                default:    n_mar = base_mar;
            endcase
        end
    end

    // Hold MAR for the next instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mar <= '0;
        end else if (i_accept) begin
            r_mar <= n_mar;
        end
    end

    // Build the issued item; ADD and SHW read the first operand, others MAR
    always_comb begin
        o_item.op     = i_op;
        o_item.form   = i_add_form;
        o_item.imm    = i_immediate;
        o_item.target = i_show_target;
        o_item.mar    = n_mar;
        o_item.addr_a = (i_op == OP_ADD || i_op == OP_SHW) ? i_first_address : base_mar;
        o_item.addr_b = i_second_address;
        o_item.a3     = i_third_address;
        o_item.a_ok   = in_range(o_item.addr_a);
        o_item.b_ok   = in_range(i_second_address);
        o_item.mar_ok = in_range(n_mar);
        o_item.a3_ok  = in_range(i_third_address);
    end

endmodule

// ===== src/amx_exec.sv =====
// Execute stage: takes memory read data, forwards the write of the previous
// instruction, updates ACC/MDR/UC/PC and holds the result register.
// Depends on amx_pkg.
module amx_exec
    import amx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_item             i_item,
    input  logic [DATA_W-1:0] i_rdata_a,
    input  logic [DATA_W-1:0] i_rdata_b,
    input  logic              i_out_ready,
    output logic              o_free,
    output t_wr               o_wr,
    output logic              o_out_valid,
    output t_result           o_result
);

    logic              r_e_valid;
    t_item             r_e;
    logic              r_fw_valid;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [DATA_W-1:0] r_fw_data;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_mdr;
    logic [DATA_W-1:0] r_pc;
    logic              r_out_valid;
    t_result           r_out;

    logic              e_adv;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic [DATA_W-1:0] sum_ab;
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] n_mdr;
    logic              show_ok;
    logic [DATA_W-1:0] show_val;
    logic              wr_req;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign e_adv  = r_e_valid && (!r_out_valid || i_out_ready);
    assign o_free = !r_e_valid || e_adv;

    // Operand fetch with forwarding, then the operation itself
    always_comb begin
        rd_a = (r_fw_valid && r_fw_addr == r_e.addr_a) ? r_fw_data : i_rdata_a;
        rd_b = (r_fw_valid && r_fw_addr == r_e.addr_b) ? r_fw_data : i_rdata_b;
        if (!r_e.a_ok) rd_a = '0;
        if (!r_e.b_ok) rd_b = '0;
        sum_ab   = rd_a + rd_b;
        n_acc    = r_acc;
        n_mdr    = r_mdr;
        show_ok  = 1'b0;
        show_val = '0;
        wr_req   = 1'b0;
        wr_addr  = r_e.mar;
        wr_data  = '0;
        unique case (r_e.op)
            OP_SET: begin
                n_mdr   = r_e.imm;
                wr_req  = r_e.mar_ok;
                wr_data = r_e.imm;
            end
            OP_LDR: begin
                n_mdr = rd_a;
                n_acc = rd_a;
            end
            OP_ADD: begin
                case (r_e.form)
                    FORM_ONE: begin
                        n_acc = r_acc + rd_a;
                        n_mdr = rd_a;
                    end
                    FORM_TWO: begin
                        n_acc = sum_ab;
                        n_mdr = rd_b;
                    end
                    FORM_THREE: begin
                        n_acc   = '0;
                        n_mdr   = r_e.a3_ok ? sum_ab : '0;
                        wr_req  = r_e.a3_ok;
                        wr_addr = r_e.a3;
                        wr_data = sum_ab;
                    end
                    default: begin
                        n_acc = r_acc;
                    end
                endcase
            end
            OP_INC: begin
                n_mdr   = rd_a + 32'd1;
                wr_req  = r_e.mar_ok;
                wr_data = rd_a + 32'd1;
            end
            OP_DEC: begin
                n_mdr   = rd_a - 32'd1;
                wr_req  = r_e.mar_ok;
                wr_data = rd_a - 32'd1;
            end
            OP_STR: begin
                n_acc   = '0;
                wr_req  = r_e.mar_ok;
                wr_data = r_acc;
            end
            OP_SHW: begin
                show_ok = 1'b1;
                case (r_e.target)
                    SHW_ACC: show_val = r_acc;
                    SHW_MAR: show_val = {{(DATA_W-ADDR_W){1'b0}}, r_e.mar};
                    SHW_MDR: show_val = r_mdr;
                    SHW_UC:  show_val = {{(DATA_W-3){1'b0}}, OP_SHW};
                    SHW_MEM: show_val = rd_a;
                    default: show_ok  = 1'b0;
                endcase
            end
            OP_PAUSE: begin
                n_acc = r_acc;
            end
        endcase
    end

    assign o_wr.en   = e_adv && wr_req;
    assign o_wr.addr = wr_addr;
    assign o_wr.data = wr_data;

    // Execute stage occupancy and forwarding of the write that each read misses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_e_valid  <= 1'b1;
                r_fw_valid <= o_wr.en;
            end else if (e_adv) begin
                r_e_valid <= 1'b0;
            end
        end
    end

    // Payload of the execute stage and forwarding data
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_e       <= i_item;
            r_fw_addr <= o_wr.addr;
            r_fw_data <= o_wr.data;
        end
    end

    // Machine registers and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_mdr       <= '0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else if (e_adv) begin
            r_acc       <= n_acc;
            r_mdr       <= n_mdr;
            r_pc        <= r_pc + 32'd1;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (e_adv) begin
            r_out.acc        <= n_acc;
            r_out.mar        <= r_e.mar;
            r_out.mdr        <= n_mdr;
            r_out.uc         <= r_e.op;
            r_out.pc         <= r_pc + 32'd1;
            r_out.show_valid <= show_ok;
            r_out.show_value <= show_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== src/accumulator_machine_executor.sv =====
// Top level of the accumulator machine executor: input unpacking, memory
// clearing after reset, two RAM copies and the issue/execute stages.
// Depends on amx_pkg, amx_ram, amx_issue and amx_exec.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: operands
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: show_valid; tdata: state
//
// One instruction per cycle sustained while m_axis_tready is high; the memory
// read and the execute stage register at the input transfer, the result
// register when the execute stage advances. Both read ports are served by
// two RAM copies written together.
// After reset the memory is zeroed word by word, while s_axis_tready stays
// low. A stalled output holds the execute stage, which in turn holds
// s_axis_tready low.
module accumulator_machine_executor
    import amx_pkg::*;
#(
    parameter int MEM_WORDS = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0]
    input  logic [2:0]   s_axis_tuser,
    // has_addresses[0], first_address[7:1], second_address[14:8],
    // third_address[21:15], add_form[23:22], immediate[55:24],
    // show_target[58:56], zero[63:59]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // show_valid[0]
    output logic         m_axis_tuser,
    // accumulator[31:0], address_reg[38:32], data_reg[70:39], unit_code[73:71],
    // program_count[105:74], show_value[137:106], zero[143:138]
    output logic [143:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(MEM_WORDS);

    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_idx;
    logic             accept;
    logic             exec_free;
    t_item            item;
    t_wr              wr;
    t_result          result;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;

    assign s_axis_tready = !r_clearing && exec_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sweep the memory to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == IDX_W'(MEM_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Write port: clearing sweep or execute stage
    assign ram_we    = r_clearing || wr.en;
    assign ram_waddr = r_clearing ? r_clr_idx : IDX_W'(wr.addr);
    assign ram_wdata = r_clearing ? '0 : wr.data;

    amx_issue #(
        .MEM_WORDS(MEM_WORDS)
    ) u_issue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_op            (t_op'(s_axis_tuser)),
        .i_has_addresses (s_axis_tdata[0]),
        .i_first_address (s_axis_tdata[7:1]),
        .i_second_address(s_axis_tdata[14:8]),
        .i_third_address (s_axis_tdata[21:15]),
        .i_add_form      (s_axis_tdata[23:22]),
        .i_immediate     (s_axis_tdata[55:24]),
        .i_show_target   (s_axis_tdata[58:56]),
        .o_item          (item)
    );

    amx_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MEM_WORDS)
    ) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (accept),
        .i_raddr(IDX_W'(item.addr_a)),
        .o_rdata(rdata_a)
    );

    amx_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MEM_WORDS)
    ) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (accept),
        .i_raddr(IDX_W'(item.addr_b)),
        .o_rdata(rdata_b)
    );

    amx_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (item),
        .i_rdata_a  (rdata_a),
        .i_rdata_b  (rdata_b),
        .i_out_ready(m_axis_tready),
        .o_free     (exec_free),
        .o_wr       (wr),
        .o_out_valid(m_axis_tvalid),
        .o_result   (result)
    );

    // Pack the result transfer
    assign m_axis_tuser  = result.show_valid;
    assign m_axis_tdata  = {6'd0, result.show_value, result.pc, result.uc,
                            result.mdr, result.mar, result.acc};

endmodule
